// ===== src/sha256bs_pkg.sv =====
// Shared types, constants and functions of the SHA-256 byte stream hasher.
// It depends on nothing and is imported by every module of the block.
package sha256bs_pkg;

  localparam logic       REQ_ABSORB = 1'b0;
  localparam logic       REQ_FINISH = 1'b1;
  localparam logic [7:0] PAD_MARKER = 8'h80;
  localparam logic [5:0] FILL_LAST  = 6'h3F;
  localparam logic [5:0] FILL_LEN   = 6'h38;
  localparam logic [5:0] ROUND_LAST = 6'h3F;
  localparam logic [2:0] WORD_LAST  = 3'h7;
  localparam logic [63:0] BITS_PER_BYTE = 64'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_UPDATE,
    ST_OUT
  } state_t;

  // Controls of the message schedule window.
  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       round_step;
    logic       expand;
  } sched_ctl_t;

  // Controls of the round unit and hash registers.
  typedef struct packed {
    logic       init_hash;
    logic       load_vars;
    logic       round_step;
    logic [5:0] round_idx;
    logic       add_hash;
    logic [2:0] out_idx;
  } core_ctl_t;

  function automatic logic [31:0] hash_init(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    case (idx)
      6'd0:  v = 32'h428a2f98; 6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf; 6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b; 6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4; 6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98; 6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be; 6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74; 6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7; 6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1; 6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6; 6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f; 6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc; 6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152; 6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8; 6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3; 6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351; 6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85; 6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc; 6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354; 6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e; 6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1; 6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70; 6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819; 6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585; 6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116; 6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c; 6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3; 6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f; 6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee; 6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814; 6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa; 6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;
      default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

// ===== src/sha256bs_sched.sv =====
// Message schedule window of the SHA-256 hasher: byte packing and word expansion.
// Depends on sha256bs_pkg.
module sha256bs_sched
  import sha256bs_pkg::*;
(
  input  logic        clk,
  input  sched_ctl_t  ctl,
  output logic [31:0] sched_word
);

  logic [31:0] window [16];
  logic [31:0] expanded;

  // The window shifts down by one word each round, so every tap is fixed.
  assign expanded = window[0] + small_sigma1(window[14]) + window[9]
                  + small_sigma0(window[1]);
  assign sched_word = ctl.expand ? expanded : window[0];

  always_ff @(posedge clk) begin
    if (ctl.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= {window[i][23:0], window[i+1][31:24]};
      end
      window[15] <= {window[15][23:0], ctl.byte_val};
    end else if (ctl.round_step) begin
      for (int i = 0; i < 15; i++) begin
        window[i] <= window[i+1];
      end
      window[15] <= sched_word;
    end
  end

endmodule

// ===== src/sha256bs_core.sv =====
// Shared SHA-256 round unit with the working variables and the hash words.
// Depends on sha256bs_pkg.
module sha256bs_core
  import sha256bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  core_ctl_t   ctl,
  input  logic [31:0] sched_word,
  output logic [31:0] hash_word
);

  logic [31:0] hash_words [8];
  logic [31:0] vars [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
  assign maj = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
  assign t1  = vars[7] + big_sigma1(vars[4]) + ch + round_k(ctl.round_idx) + sched_word;
  assign t2  = big_sigma0(vars[0]) + maj;

  assign hash_word = hash_words[ctl.out_idx];

  always_ff @(posedge clk) begin
    if (rst || ctl.init_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_words[i] <= hash_init(3'(i));
      end
    end else if (ctl.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_words[i] <= hash_words[i] + vars[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_vars) begin
      for (int i = 0; i < 8; i++) begin
        vars[i] <= hash_words[i];
      end
    end else if (ctl.round_step) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

// ===== src/sha256_byte_stream_hasher_unit.sv =====
// Top level of the SHA-256 byte stream hasher: sequencer, byte counter and bit count.
// Depends on sha256bs_pkg, sha256bs_sched and sha256bs_core.
//
// The unit hashes a byte stream with SHA-256. An absorb item carries one message
// byte and is taken while the unit is idle. Every 64th byte starts a compression
// that runs one round per cycle through a single shared round unit and then folds
// the result into the hash words; in_stall is high while it runs. A finish item
// appends the standard padding one byte per cycle (the 0x80 marker, zero bytes up
// to byte 56 of a block, then the 64-bit bit count, big-endian), compressing once
// or twice on the way, and then presents the eight digest words as eight items,
// word 0 first, with last_word set on the eighth. The data byte of a finish item is
// ignored. The bit count wraps modulo 2^64. When the eighth word is taken the unit
// returns to the initial hash state and is ready for a new message.
module sha256_byte_stream_hasher_unit
  import sha256bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  state_t      state;
  state_t      state_next;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [5:0]  round_cnt;
  logic [2:0]  out_idx;
  logic        finishing;
  logic        len_phase;

  logic        in_acc;
  logic        out_acc;
  logic        out_done;
  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  len_byte;
  logic [2:0]  len_sel;
  logic        use_len;
  logic [31:0] sched_word;
  sched_ctl_t  sched_ctl;
  core_ctl_t   core_ctl;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign out_done = out_acc && (out_idx == WORD_LAST);

  // Length bytes go out most significant first, one per fill position 56..63.
  assign len_sel  = WORD_LAST - fill[2:0];
  assign len_byte = message_bits[{len_sel, 3'b000} +: 8];
  assign use_len  = len_phase || (fill == FILL_LEN);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (fill == FILL_LAST) begin
            state_next = ST_COMPRESS;
          end else if (req_type == REQ_FINISH) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (fill == FILL_LAST) begin
          state_next = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        if (round_cnt == ROUND_LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (len_phase) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_OUT: begin
        if (out_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs and datapath controls.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    push      = 1'b0;
    push_byte = data_byte;
    core_ctl  = '0;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        push      = in_acc;
        push_byte = (req_type == REQ_FINISH) ? PAD_MARKER : data_byte;
      end
      ST_PAD: begin
        push      = 1'b1;
        push_byte = use_len ? len_byte : 8'h00;
      end
      ST_COMPRESS: begin
        core_ctl.round_step = 1'b1;
      end
      ST_UPDATE: begin
        core_ctl.add_hash = 1'b1;
      end
      ST_OUT: begin
        out_valid          = 1'b1;
        core_ctl.init_hash = out_done;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
    // The working variables are loaded from the hash words on the byte that completes a block.
    core_ctl.load_vars = push && (fill == FILL_LAST);
    core_ctl.round_idx = round_cnt;
    core_ctl.out_idx   = out_idx;

    sched_ctl.shift_byte = push;
    sched_ctl.byte_val   = push_byte;
    sched_ctl.round_step = (state == ST_COMPRESS);
    sched_ctl.expand     = (round_cnt[5:4] != 2'b00);
  end

  assign word_index = out_idx;
  assign last_word  = (out_idx == WORD_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= '0;
      message_bits <= '0;
      round_cnt    <= '0;
      out_idx      <= '0;
      finishing    <= 1'b0;
      len_phase    <= 1'b0;
    end else begin
      state <= state_next;
      if (push) begin
        fill <= fill + 6'd1;
      end
      if (state == ST_COMPRESS) begin
        round_cnt <= round_cnt + 6'd1;
      end
      if (in_acc && req_type == REQ_ABSORB) begin
        message_bits <= message_bits + BITS_PER_BYTE;
      end else if (out_done) begin
        message_bits <= '0;
      end
      if (in_acc && req_type == REQ_FINISH) begin
        finishing <= 1'b1;
      end else if (out_done) begin
        finishing <= 1'b0;
      end
      if (state == ST_PAD && use_len) begin
        len_phase <= 1'b1;
      end else if (out_done) begin
        len_phase <= 1'b0;
      end
      if (out_acc) begin
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  sha256bs_sched u_sched (
    .clk        (clk),
    .ctl        (sched_ctl),
    .sched_word (sched_word)
  );

  sha256bs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .ctl        (core_ctl),
    .sched_word (sched_word),
    .hash_word  (digest_word)
  );

endmodule

// ===== dv/sha256_digest_checker.sv =====
// Checker for the SHA-256 byte stream hasher: it watches both item channels, keeps its own
// hash of the byte stream and compares every digest word against the expected one.
// Depends on sha256bs_pkg for the request codes and padding constants.
module sha256_digest_checker
  import sha256bs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        req_type,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] digest_word,
  input  logic [2:0]  word_index,
  input  logic        last_word,
  output int          pending_words,
  output int          fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  localparam logic [0:63][31:0] ROUND_CONST = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [0:7][31:0] HASH_IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic [31:0]  chain_hash [8];
  logic [7:0]   block_bytes [64];
  int           block_len;
  logic [63:0]  bit_length;
  int           failures = 0;
  digest_item_t expected_digest_words [$];

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One full SHA-256 compression of the gathered 64-byte block into the chaining value.
  function automatic void compress_block_bytes();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = w[i-16] + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
           + w[i-7] + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
    a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
    e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
    for (int r = 0; r < 64; r++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
         + ROUND_CONST[r] + w[r];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
    chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
  endfunction

  function automatic void take_byte(input logic [7:0] value);
    block_bytes[block_len] = value;
    block_len++;
    if (block_len == 64) begin
      compress_block_bytes();
      block_len = 0;
    end
  endfunction

  function automatic void start_message();
    for (int i = 0; i < 8; i++)
      chain_hash[i] = HASH_IV[i];
    block_len = 0;
    bit_length = '0;
  endfunction

  // Padding uses the bit count as it stood before the marker byte went in.
  function automatic void close_message();
    logic [63:0] len_bits;
    digest_item_t item;
    len_bits = bit_length;
    take_byte(PAD_MARKER);
    while (block_len != int'(FILL_LEN))
      take_byte(8'h00);
    for (int i = 0; i < 8; i++)
      take_byte(len_bits[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) begin
      item.word  = chain_hash[i];
      item.index = 3'(i);
      item.last  = (3'(i) == WORD_LAST);
      expected_digest_words.push_back(item);
    end
    start_message();
  endfunction

  always @(posedge clk) begin : watch_channels
    digest_item_t want;
    if (rst) begin
      start_message();
      expected_digest_words.delete();
    end else begin
      if (in_valid && !in_stall) begin
        if (req_type == REQ_FINISH) begin
          close_message();
        end else begin
          take_byte(data_byte);
          bit_length += BITS_PER_BYTE;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_digest_words.size() == 0) begin
          if (failures < REPORT_LIMIT)
            $display("unexpected digest item: word %h index %0d last %0b",
                     digest_word, word_index, last_word);
          failures++;
        end else begin
          want = expected_digest_words.pop_front();
          if (digest_word !== want.word || word_index !== want.index ||
              last_word !== want.last) begin
            if (failures < REPORT_LIMIT)
              $display("digest mismatch: expected word %h index %0d last %0b, got %h %0d %0b",
                       want.word, want.index, want.last, digest_word, word_index, last_word);
            failures++;
          end
        end
      end
    end
    pending_words <= expected_digest_words.size();
    fail_count <= failures;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the SHA-256 byte stream hasher testbench: clock, reset, item stimulus and verdict.
// Depends on sha256bs_pkg, sha256_byte_stream_hasher_unit and sha256_digest_checker.
module testbench
  import sha256bs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // The limit lies well beyond the slowest legal run, so this only trips on a hang.
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int RANDOM_ITEMS = 430;
  // Quiet time after the last expected digest word, so a stray extra item is still seen.
  localparam int DRAIN_CYCLES = 150;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY,
    STALL_TOGGLE
  } stall_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_ABSORB;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          pending_words;
  int          fail_count;

  stall_mode_t stall_mode = STALL_NONE;
  logic [7:0]  stall_left = 8'd0;
  int          burst_left = 0;
  int          cycle_count = 0;

  always #1 clk = ~clk;

  sha256_byte_stream_hasher_unit uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digest_word(digest_word),
    .word_index (word_index),
    .last_word  (last_word)
  );

  sha256_digest_checker checker_inst (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .req_type     (req_type),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word),
    .pending_words(pending_words),
    .fail_count   (fail_count)
  );

  // The digest receiver changes its stall behavior each time its countdown runs out: no stall at all,
  // coin flips, long stall runs, or a strict toggle. That moves stalls across every digest
  // word position and across the cycles where the unit is still padding or compressing.
  always @(posedge clk) begin
    if (stall_left == 8'd0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= 8'($urandom_range(10, 60));
    end else begin
      stall_left <= stall_left - 8'd1;
    end
    case (stall_mode)
      STALL_NONE:   out_stall <= 1'b0;
      STALL_RANDOM: out_stall <= ($urandom_range(0, 1) == 1);
      STALL_BURSTY: out_stall <= (stall_left[2:0] < 3'd5);
      default:      out_stall <= ~out_stall;
    endcase
  end

  // Sends one item and returns just after the edge at which it was accepted. Items go out in
  // bursts; between bursts the valid drops for a random gap. Within a burst valid stays high,
  // so the next payload is placed with a single assignment in the same step.
  task automatic send_item(input logic kind, input logic [7:0] value);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid  <= 1'b1;
    req_type  <= kind;
    data_byte <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hang guard: if the run has not finished by the limit, something is stuck.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sha256_byte_stream_hasher_unit verification failed");
    $finish;
  end

  initial begin : stimulus
    int          items_sent;
    int          msg_len;
    logic [7:0]  value;
    items_sent = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty message, with a nonzero byte on the finish item that must be ignored.
    send_item(REQ_FINISH, 8'hFF);
    // The classic three-byte message "abc".
    send_item(REQ_ABSORB, 8'h61);
    send_item(REQ_ABSORB, 8'h62);
    send_item(REQ_ABSORB, 8'h63);
    send_item(REQ_FINISH, 8'h00);
    // Byte extremes and the marker value itself as message data.
    send_item(REQ_ABSORB, 8'hFF);
    send_item(REQ_ABSORB, 8'h00);
    send_item(REQ_ABSORB, 8'h80);
    send_item(REQ_ABSORB, 8'h7F);
    send_item(REQ_ABSORB, 8'h01);
    send_item(REQ_FINISH, 8'hA5);
    // Two finishes in a row: the unit must be back at its initial hash state.
    send_item(REQ_FINISH, 8'h5A);
    // Single zero byte.
    send_item(REQ_ABSORB, 8'h00);
    send_item(REQ_FINISH, 8'hFF);
    // A run of all-ones bytes that fills two whole schedule words.
    for (int i = 0; i < 8; i++)
      send_item(REQ_ABSORB, 8'hFF);
    send_item(REQ_FINISH, 8'h00);

    // Random messages. Most are short, some sit right on the padding boundaries (a length
    // of 55 still pads in one block, 56 and 120 spill into a further one, 64 ends exactly
    // on a block), and some span more than one block.
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: msg_len = $urandom_range(0, 24);
        12, 13, 14, 15, 16: begin
          case ($urandom_range(0, 6))
            0: msg_len = 55;
            1: msg_len = 56;
            2: msg_len = 63;
            3: msg_len = 64;
            4: msg_len = 65;
            5: msg_len = 119;
            default: msg_len = 120;
          endcase
        end
        default: msg_len = $urandom_range(25, 70);
      endcase
      for (int i = 0; i < msg_len; i++) begin
        case ($urandom_range(0, 7))
          0: value = 8'h00;
          1: value = 8'hFF;
          default: value = 8'($urandom);
        endcase
        send_item(REQ_ABSORB, value);
      end
      send_item(REQ_FINISH, 8'($urandom));
      items_sent += msg_len + 1;
    end

    // The checker's counters are registered, so wait for a clock edge before looking at them.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("sha256_byte_stream_hasher_unit verification clean");
    end else begin
      $display("sha256_byte_stream_hasher_unit verification failed");
    end
    $finish;
  end

endmodule
